/* src/spectral_helmholtz_projection_unit_defines.svh */
// assertion macros for the helmholtz projection block
// the macros rely on clk_i and rst_ni in the module that uses them
`ifndef SPECTRAL_HELMHOLTZ_PROJECTION_UNIT_DEFINES_SVH
`define SPECTRAL_HELMHOLTZ_PROJECTION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SHP_ASSERT_IF(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);
`else
`define SHP_ASSERT(label, prop, msg)
`define SHP_ASSERT_IF(label, cond, prop, msg)
`endif
`endif

/* src/shp_pkg.sv */
`default_nettype none
package shp_pkg;

  // field widths
  localparam int IDX_W    = 10;
  localparam int SIZE_W   = 11;
  localparam int MAG_W    = 11;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int K2_W     = 24;
  localparam int RAD_SHIFT = 36;
  localparam int RAD_W    = 62;
  localparam int ROOT_W   = 30;
  localparam int NUM_SHIFT = 48;
  localparam int REM_W    = 62;
  localparam int QUO_W    = 31;
  localparam int KHAT_W   = 32;
  localparam int AMP_W    = 32;
  localparam int PROD_W   = 64;
  localparam int DOT_W    = 35;
  localparam int TERM_W   = 35;
  localparam int FRAC_W   = 30;

  localparam int N_AXES   = 3;
  localparam int N_PARTS  = 2;
  localparam int N_AMP    = N_AXES * N_PARTS;

  localparam int IN_RAW_W     = N_AXES * IDX_W + N_AMP * AMP_W;
  localparam int IN_TDATA_W   = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = N_AMP * AMP_W;
  localparam int AMP_LSB      = N_AXES * IDX_W;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = SIZE_W;

  localparam int DEF_MAX_GRID  = 1024;
  localparam int DEF_AMP_WIDTH = 32;
  localparam logic [SIZE_W-1:0] GRID_RESET = SIZE_W'(64);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GRID_X = 2'd0,
    REG_GRID_Y = 2'd1,
    REG_GRID_Z = 2'd2,
    REG_MODE   = 2'd3
  } cfg_reg_e;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DOT_W-1:0]  dot_t;

  // item fields carried around the sqrt and divider pipes
  typedef struct packed {
    logic                               zero;
    logic [N_AXES-1:0]                  neg;
    logic [N_AXES-1:0][MAG_W-1:0]       mag;
    logic [N_AMP-1:0][AMP_W-1:0]        amp;
  } pay_t;

  // divide by 2^30, rounding half away from zero
  function automatic prod_t round30(input prod_t x);
    logic [PROD_W-1:0] mag;
    mag = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
    mag = (mag + (PROD_W'(1) << (FRAC_W - 1))) >> FRAC_W;
    return x[PROD_W-1] ? -prod_t'(mag) : prod_t'(mag);
  endfunction

endpackage
`default_nettype wire

/* src/shp_delay.sv */
`default_nettype none
module shp_delay import shp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  logic [DEPTH-1:0]            valid_q;
  logic [DEPTH-1:0][WIDTH-1:0] data_q;

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int s = 1; s < DEPTH; s++) valid_q[s] <= valid_q[s-1];
    end
  end

  // payload line
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q[0] <= data_i;
      for (int s = 1; s < DEPTH; s++) data_q[s] <= data_q[s-1];
    end
  end

  assign valid_o = valid_q[DEPTH-1];
  assign data_o  = data_q[DEPTH-1];

endmodule
`default_nettype wire

/* src/shp_sqrt.sv */
`default_nettype none
module shp_sqrt import shp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0]      root_o
);

  logic [RAD_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  // one root bit per stage, msb first
  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int B = ROOT_W - 1 - s;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  trial;

    if (s == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign trial = (RAD_W'(root_in) << (B + 1)) + (RAD_W'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[s]  <= rem_in - trial;
          root_q[s] <= root_in | (ROOT_W'(1) << B);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule
`default_nettype wire

/* src/shp_div.sv */
`default_nettype none
module shp_div import shp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [REM_W-1:0]  num_i,
  input  wire logic [ROOT_W-1:0] den_i,
  output logic [QUO_W-1:0]       quo_o
);

  logic [REM_W-1:0]  rem_q [QUO_W];
  logic [ROOT_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0]  quo_q [QUO_W];

  // restoring division, one quotient bit per stage
  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int J = QUO_W - 1 - s;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] den_in;
    logic [QUO_W-1:0]  quo_in;
    logic [REM_W-1:0]  trial;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = REM_W'(den_in) << J;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= den_in;
        if (rem_in >= trial) begin
          rem_q[s] <= rem_in - trial;
          quo_q[s] <= quo_in | (QUO_W'(1) << J);
        end else begin
          rem_q[s] <= rem_in;
          quo_q[s] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule
`default_nettype wire

/* src/shp_merge.sv */
`default_nettype none
module shp_merge import shp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire prod_t prod_i [N_AMP],
  output dot_t       dot_o  [N_PARTS]
);

  prod_t acc_q [N_PARTS];
  dot_t  dot_q [N_PARTS];

  // sum the lane products, then round back to q16.16
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int p = 0; p < N_PARTS; p++) begin
        acc_q[p] <= prod_i[p] + prod_i[N_PARTS + p] + prod_i[2 * N_PARTS + p];
        dot_q[p] <= DOT_W'(round30(acc_q[p]));
      end
    end
  end

  assign dot_o = dot_q;

endmodule
`default_nettype wire

/* src/spectral_helmholtz_projection_unit.sv */
// channel   | dir | handshake              | payload
// s_axis    | in  | tvalid / tready        | grid indices and complex amplitude
// m_axis    | out | tvalid / tready        | projected complex amplitude
// cfg       | in  | cfg_we_i               | grid sizes and projection mode
//
// one transaction per cycle while the output is not stalled
// latency is set by the 30-stage square root and the 31-stage dividers
// reset clears all valid bits and loads the register defaults
// a stalled output freezes the whole pipe and drops s_axis_tready
`default_nettype none
`include "spectral_helmholtz_projection_unit_defines.svh"
module spectral_helmholtz_projection_unit import shp_pkg::*; #(
  parameter int MAX_GRID  = DEF_MAX_GRID,
  parameter int AMP_WIDTH = DEF_AMP_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // index_x, index_y, index_z, amp_x_real, amp_x_imag, amp_y_real,
  // amp_y_imag, amp_z_real, amp_z_imag, zero fill
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // proj_x_real, proj_x_imag, proj_y_real, proj_y_imag, proj_z_real, proj_z_imag
  output logic [OUT_TDATA_W-1:0]     m_axis_tdata,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam longint AMP_MAXV = (64'sd1 <<< (AMP_WIDTH - 1)) - 64'sd1;
  localparam longint AMP_MINV = -AMP_MAXV - 64'sd1;
  localparam logic [AMP_W-1:0] AMP_MASK = AMP_W'((64'd1 << AMP_WIDTH) - 64'd1);
  localparam int AMP_PAD = AMP_W - AMP_WIDTH;
  localparam longint KHAT_ONE = 64'sd1 <<< FRAC_W;
  localparam longint DOT_LIM  = 64'sd3 <<< 31;

  logic en;

  // configuration registers
  logic [N_AXES-1:0][SIZE_W-1:0] size_q;
  logic                          mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= {N_AXES{GRID_RESET}};
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_GRID_X: size_q[0] <= cfg_wdata_i;
        REG_GRID_Y: size_q[1] <= cfg_wdata_i;
        REG_GRID_Z: size_q[2] <= cfg_wdata_i;
        REG_MODE:   mode_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // global advance: move whenever the output slot is free or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // wavenumber by the fftfreq rule, amplitude sign extension
  pay_t in_pay;

  always_comb begin
    logic [SIZE_W-1:0] nn;
    logic [IDX_W-1:0]  idx;
    logic              low;
    logic signed [SIZE_W:0] k;
    logic [AMP_W-1:0]  raw;
    in_pay = '0;
    for (int c = 0; c < N_AXES; c++) begin
      idx = s_axis_tdata[c*IDX_W +: IDX_W];
      nn  = (32'(size_q[c]) > MAX_GRID) ? SIZE_W'(MAX_GRID) : size_q[c];
      low = nn[0] ? ({1'b0, idx} <= (nn >> 1)) : ({1'b0, idx} < (nn >> 1));
      k   = low ? $signed({2'b00, idx}) : $signed({2'b00, idx}) - $signed({1'b0, nn});
      in_pay.neg[c] = k[SIZE_W];
      in_pay.mag[c] = k[SIZE_W] ? MAG_W'(-k) : MAG_W'(k);
    end
    for (int a = 0; a < N_AMP; a++) begin
      raw = s_axis_tdata[AMP_LSB + a*AMP_W +: AMP_W];
      in_pay.amp[a] = AMP_W'($signed(raw << AMP_PAD) >>> AMP_PAD);
    end
  end

  // stage a: capture, stage b: squares, stage c: |k|^2
  logic a_valid_q, b_valid_q, c_valid_q;
  pay_t a_pay_q, b_pay_q, c_pay_q;
  logic [N_AXES-1:0][SQ_W-1:0] b_sq_q;
  logic [K2_W-1:0] c_k2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= s_axis_tvalid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_pay_q <= in_pay;
      b_pay_q <= a_pay_q;
      for (int c = 0; c < N_AXES; c++) b_sq_q[c] <= a_pay_q.mag[c] * a_pay_q.mag[c];
      c_pay_q <= {(b_sq_q[0] == '0) && (b_sq_q[1] == '0) && (b_sq_q[2] == '0),
                  b_pay_q.neg, b_pay_q.mag, b_pay_q.amp};
      c_k2_q  <= K2_W'(b_sq_q[0]) + K2_W'(b_sq_q[1]) + K2_W'(b_sq_q[2]);
    end
  end

  // |k| in q18
  logic [ROOT_W-1:0] root;
  logic              s_valid;
  pay_t              s_pay;

  shp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (RAD_W'({c_k2_q, RAD_SHIFT'(0)})),
    .root_o (root)
  );

  shp_delay #(.WIDTH($bits(pay_t)), .DEPTH(ROOT_W)) u_dly_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid_q),
    .data_i  (c_pay_q),
    .valid_o (s_valid),
    .data_o  (s_pay)
  );

  // one divider lane per axis
  logic [QUO_W-1:0] quo [N_AXES];
  logic             q_valid;
  pay_t             q_pay;

  for (genvar c = 0; c < N_AXES; c++) begin : g_lane
    shp_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ((REM_W'(s_pay.mag[c]) << NUM_SHIFT) + REM_W'(root >> 1)),
      .den_i (root),
      .quo_o (quo[c])
    );
  end

  shp_delay #(.WIDTH($bits(pay_t)), .DEPTH(QUO_W)) u_dly_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .data_i  (s_pay),
    .valid_o (q_valid),
    .data_o  (q_pay)
  );

  // stage d: signed unit vector, stage e: lane products
  logic d_valid_q, e_valid_q;
  logic [N_AMP-1:0][AMP_W-1:0]   d_amp_q, e_amp_q;
  logic [N_AXES-1:0][KHAT_W-1:0] d_khat_q, e_khat_q;
  prod_t e_prod_q [N_AMP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= q_valid;
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_amp_q <= q_pay.amp;
      for (int c = 0; c < N_AXES; c++) begin
        if (q_pay.zero) begin
          d_khat_q[c] <= '0;
        end else if (q_pay.neg[c]) begin
          d_khat_q[c] <= -KHAT_W'(quo[c]);
        end else begin
          d_khat_q[c] <= KHAT_W'(quo[c]);
        end
      end
      e_amp_q  <= d_amp_q;
      e_khat_q <= d_khat_q;
      for (int a = 0; a < N_AMP; a++) begin
        e_prod_q[a] <= $signed(d_amp_q[a]) * $signed(d_khat_q[a / N_PARTS]);
      end
    end
  end

  // merge the lanes into the complex dot product
  dot_t dot [N_PARTS];
  logic m_valid;
  logic [N_AMP*AMP_W + N_AXES*KHAT_W - 1:0] m_side;

  shp_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .prod_i (e_prod_q),
    .dot_o  (dot)
  );

  shp_delay #(.WIDTH(N_AMP*AMP_W + N_AXES*KHAT_W), .DEPTH(2)) u_dly_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_valid_q),
    .data_i  ({e_amp_q, e_khat_q}),
    .valid_o (m_valid),
    .data_o  (m_side)
  );

  logic [N_AMP-1:0][AMP_W-1:0]   m_amp;
  logic [N_AXES-1:0][KHAT_W-1:0] m_khat;
  assign {m_amp, m_khat} = m_side;

  // stage h: project back, stage i: round, stage j: combine and saturate
  logic h_valid_q, i_valid_q;
  logic [N_AMP-1:0][AMP_W-1:0] h_amp_q, i_amp_q;
  prod_t h_tp_q [N_AMP];
  logic signed [TERM_W-1:0] i_term_q [N_AMP];
  logic [N_AMP-1:0][AMP_W-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q     <= 1'b0;
      i_valid_q     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      h_valid_q     <= m_valid;
      i_valid_q     <= h_valid_q;
      m_axis_tvalid <= i_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [TERM_W:0] r;
    logic signed [TERM_W:0] sat;
    if (en) begin
      h_amp_q <= m_amp;
      i_amp_q <= h_amp_q;
      for (int a = 0; a < N_AMP; a++) begin
        h_tp_q[a]   <= PROD_W'($signed(dot[a % N_PARTS]) * $signed(m_khat[a / N_PARTS]));
        i_term_q[a] <= TERM_W'(round30(h_tp_q[a]));
        r = mode_q ? (TERM_W+1)'(i_term_q[a])
                   : (TERM_W+1)'($signed(i_amp_q[a])) - (TERM_W+1)'(i_term_q[a]);
        if (r > AMP_MAXV) begin
          sat = (TERM_W+1)'(AMP_MAXV);
        end else if (r < AMP_MINV) begin
          sat = (TERM_W+1)'(AMP_MINV);
        end else begin
          sat = r;
        end
        out_q[a] <= AMP_W'(sat) & AMP_MASK;
      end
    end
  end

  assign m_axis_tdata = out_q;

  // unit vector components never exceed one
  `SHP_ASSERT_IF(a_khat_unit, d_valid_q,
    ($signed(d_khat_q[0]) <= KHAT_ONE) && ($signed(d_khat_q[0]) >= -KHAT_ONE) &&
    ($signed(d_khat_q[1]) <= KHAT_ONE) && ($signed(d_khat_q[1]) >= -KHAT_ONE) &&
    ($signed(d_khat_q[2]) <= KHAT_ONE) && ($signed(d_khat_q[2]) >= -KHAT_ONE),
    "unit vector component out of range")
  // the dot product stays within three full-scale amplitudes
  `SHP_ASSERT_IF(a_dot_bound, m_valid,
    ($signed(dot[0]) <= DOT_LIM) && ($signed(dot[0]) >= -DOT_LIM) &&
    ($signed(dot[1]) <= DOT_LIM) && ($signed(dot[1]) >= -DOT_LIM),
    "dot product out of range")
  // a zero wave vector gives a zero unit vector
  `SHP_ASSERT_IF(a_zero_khat, q_valid && q_pay.zero && en, ##1 (d_khat_q == '0),
    "zero wave vector gave nonzero unit vector")

endmodule
`default_nettype wire
